@@ sv/upc_pkg.sv @@
// Shared types and constants of the URL percent codec.
package upc_pkg;

   localparam int MaxResults = 7;
   localparam int CountW     = $clog2(MaxResults + 1);

   // Encoder lookahead codes; the unused code acts as LaDigit.
   localparam logic [1:0] LaNone  = 2'd0;
   localparam logic [1:0] LaPct   = 2'd1;
   localparam logic [1:0] LaDigit = 2'd2;

   // Decoder phase codes; the unused code acts as DecLow.
   localparam logic [1:0] DecIdle = 2'd0;
   localparam logic [1:0] DecHigh = 2'd1;
   localparam logic [1:0] DecLow  = 2'd2;

   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] la_count;
      logic [7:0] la_digit;
      logic [1:0] dec_phase;
      logic [5:0] dec_high;
   } codec_state_type;

   typedef struct packed {
      rsp_type [MaxResults-1:0] entry;
      logic [CountW-1:0]        count;
   } burst_type;

endpackage

@@ sv/url_percent_codec.sv @@
// Top level of the URL percent codec: state registers, handshakes and result buffer.
//
// The block converts a byte stream. With direction 0 it percent-encodes: letters, digits
// and - . _ ~ pass through, a '%' followed by two hex digits passes unchanged, and any
// other byte becomes '%' plus two lower-case hex digits. With direction 1 it decodes
// '%' plus two digit bytes into one byte. in_last marks the end of a string and flushes
// any pending lookahead; out_last marks the final byte that string produces.
//
// Channels: req_ takes one item per accepted cycle (req_valid high, req_stall low).
// rsp_ delivers result bytes under the same rule with rsp_stall driven by the receiver.
// csr_ writes the direction register; it is always ready and clears the codec state.
// Write it only while no results are pending.
//
// Each accepted item is converted in the cycle it is accepted and its zero to seven
// result bytes appear from the next cycle on, one per cycle while rsp_stall is low,
// from a shift buffer. A new item is taken when the buffer is empty or delivers its
// last byte in the same cycle, so with no stall a one-byte item sustains one item per cycle
// and an escaped byte holds off the next until its three bytes pass the one-byte port.
//
// A synchronous reset empties the buffer, selects encoding and clears all lookahead.
// While rsp_stall is high the head byte holds and intake stops once the buffer is busy.
module url_percent_codec
   import upc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   logic            dir_ff;
   logic            dir_in;
   codec_state_type st_ff;
   codec_state_type st_in;
   codec_state_type st_next;
   burst_type       burst;
   logic            accept;
   logic            pop;
   logic            not_empty;
   logic            one_left;
   logic            csr_write;

   // The converter looks at the incoming byte directly; its outcome lands in registers.
   upc_core u_core (
      .dir     (dir_ff),
      .req     (req_payload),
      .st      (st_ff),
      .st_next (st_next),
      .burst   (burst)
   );

   upc_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && (burst.count != '0)),
      .burst     (burst),
      .pop       (pop),
      .head      (rsp_payload),
      .not_empty (not_empty),
      .one_left  (one_left)
   );

   assign rsp_valid = not_empty;
   assign pop       = not_empty && !rsp_stall;

   // Room for a new burst exists when the buffer is empty or is handing out its last byte.
   assign req_stall = !(!not_empty || (one_left && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // A direction write drops any pending lookahead without producing output.
   always_comb begin
      dir_in = dir_ff;
      st_in  = st_ff;
      if (csr_write) begin
         dir_in = csr_wdata;
         st_in  = '0;
      end else if (accept) begin
         st_in = st_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DirEncode;
         st_ff  <= '0;
      end else begin
         dir_ff <= dir_in;
         st_ff  <= st_in;
      end
   end

endmodule

@@ sv/upc_core.sv @@
// Combinational step of the codec: one input byte and the state give a burst and the next state.
module upc_core
   import upc_pkg::*;
(
   input  logic            dir,
   input  req_type         req,
   input  codec_state_type st,
   output codec_state_type st_next,
   output burst_type       burst
);

   localparam logic [7:0] ChPct   = 8'h25;
   localparam logic [7:0] ChTwo   = 8'h32;
   localparam logic [7:0] ChFive  = 8'h35;
   localparam logic [7:0] ChDash  = 8'h2D;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChUnder = 8'h5F;
   localparam logic [7:0] ChTilde = 8'h7E;

   function automatic logic is_num(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_num(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_plain(input logic [7:0] c);
      return is_num(c) || is_upper(c) || is_lower(c) || (c == ChDash) || (c == ChDot)
             || (c == ChUnder) || (c == ChTilde);
   endfunction

   // Letters map to 10 plus their alphabet offset, digits to their value, anything else to 0.
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (is_upper(c)) begin
         v = c - 8'd55;
      end else if (is_lower(c)) begin
         v = c - 8'd87;
      end else if (is_num(c)) begin
         v = c - 8'h30;
      end
      return v[5:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'd87 + {4'd0, nib};
      end
      return r;
   endfunction

   logic [7:0]        b;
   logic              last;
   logic [CountW-1:0] n;
   logic [1:0]        cnt;
   logic [7:0]        dig;
   logic [1:0]        ph;
   logic [5:0]        hi;
   logic              do_new;
   rsp_type [MaxResults-1:0] ents;

   always_comb begin
      b      = req.in_byte;
      last   = req.in_last;
      n      = '0;
      ents   = '0;
      cnt    = st.la_count;
      dig    = st.la_digit;
      ph     = st.dec_phase;
      hi     = st.dec_high;
      do_new = 1'b0;

      if (dir == DirEncode) begin
         unique case (cnt)
            LaNone: begin
               do_new = 1'b1;
            end
            LaPct: begin
               if (is_hex(b)) begin
                  dig = b;
                  cnt = LaDigit;
               end else begin
                  ents[n].out_byte = ChPct;  n = n + 1'b1;
                  ents[n].out_byte = ChTwo;  n = n + 1'b1;
                  ents[n].out_byte = ChFive; n = n + 1'b1;
                  cnt    = LaNone;
                  do_new = 1'b1;
               end
            end
            default: begin
               if (is_hex(b)) begin
                  ents[n].out_byte = ChPct; n = n + 1'b1;
                  ents[n].out_byte = dig;   n = n + 1'b1;
                  ents[n].out_byte = b;     n = n + 1'b1;
                  cnt = LaNone;
               end else begin
                  ents[n].out_byte = ChPct;  n = n + 1'b1;
                  ents[n].out_byte = ChTwo;  n = n + 1'b1;
                  ents[n].out_byte = ChFive; n = n + 1'b1;
                  ents[n].out_byte = dig;    n = n + 1'b1;
                  cnt    = LaNone;
                  do_new = 1'b1;
               end
            end
         endcase

         if (do_new) begin
            if (is_plain(b)) begin
               ents[n].out_byte = b; n = n + 1'b1;
            end else if (b == ChPct) begin
               cnt = LaPct;
            end else begin
               ents[n].out_byte = ChPct;          n = n + 1'b1;
               ents[n].out_byte = hex_char(b[7:4]); n = n + 1'b1;
               ents[n].out_byte = hex_char(b[3:0]); n = n + 1'b1;
            end
         end

         // End of string: a pending escape that never completed goes out as "%25" plus any held digit.
         if (last) begin
            if (cnt == LaPct) begin
               ents[n].out_byte = ChPct;  n = n + 1'b1;
               ents[n].out_byte = ChTwo;  n = n + 1'b1;
               ents[n].out_byte = ChFive; n = n + 1'b1;
            end else if (cnt != LaNone) begin
               ents[n].out_byte = ChPct;  n = n + 1'b1;
               ents[n].out_byte = ChTwo;  n = n + 1'b1;
               ents[n].out_byte = ChFive; n = n + 1'b1;
               ents[n].out_byte = dig;    n = n + 1'b1;
            end
            cnt = LaNone;
            dig = 8'd0;
         end
      end else begin
         unique case (ph)
            DecIdle: begin
               if (b == ChPct) begin
                  ph = DecHigh;
               end else begin
                  ents[n].out_byte = b; n = n + 1'b1;
               end
            end
            DecHigh: begin
               hi = digit_value(b);
               ph = DecLow;
            end
            default: begin
               ents[n].out_byte = {hi[3:0], 4'd0} | {2'd0, digit_value(b)};
               n  = n + 1'b1;
               ph = DecIdle;
               hi = 6'd0;
            end
         endcase

         // Missing digits at the end of the string count as zero.
         if (last) begin
            if (ph == DecHigh) begin
               ents[n].out_byte = 8'd0; n = n + 1'b1;
            end else if (ph != DecIdle) begin
               ents[n].out_byte = {hi[3:0], 4'd0}; n = n + 1'b1;
            end
            ph = DecIdle;
            hi = 6'd0;
         end
      end

      if (last && (n != '0)) begin
         ents[n - 1'b1].out_last = 1'b1;
      end

      st_next.la_count  = cnt;
      st_next.la_digit  = dig;
      st_next.dec_phase = ph;
      st_next.dec_high  = hi;
      burst.entry       = ents;
      burst.count       = n;
   end

endmodule

@@ sv/upc_burst.sv @@
// Result buffer that holds one item's burst and shifts it out one byte per cycle while pop is high.
module upc_burst
   import upc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   input  logic      pop,
   output rsp_type   head,
   output logic      not_empty,
   output logic      one_left
);

   rsp_type [MaxResults-1:0] entry_ff;
   rsp_type [MaxResults-1:0] entry_in;
   logic [CountW-1:0]        count_ff;
   logic [CountW-1:0]        count_in;

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = burst.entry;
         count_in = burst.count;
      end else if (pop) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign head      = entry_ff[0];
   assign not_empty = (count_ff != '0);
   assign one_left  = (count_ff == CountW'(1));

endmodule
